// ===== sv/duplicate_filter_with_aging_defines.svh =====
// Assertion macros used by the duplicate filter top level.
`ifndef DUPLICATE_FILTER_WITH_AGING_DEFINES_SVH
`define DUPLICATE_FILTER_WITH_AGING_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define DFA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("duplicate filter assertion failed");

// Checks that a condition holds in the cycle after its trigger.
`define DFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("duplicate filter assertion failed");

`endif

// ===== sv/dfa_pkg.sv =====
// Types, constants and codes shared by the duplicate filter modules.
`default_nettype none
package dfa_pkg;

  localparam int ENTRIES_DEF = 8;
  localparam int PAT_W       = 16;
  localparam int CNT_W       = 16;
  localparam int SLOT_W      = 3;
  localparam int MASK_W      = 8;

  localparam logic [CNT_W-1:0] TIMEOUT_RST = 16'd100;

  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef struct packed {
    logic             func;
    logic [PAT_W-1:0] pattern;
  } item_t;

  typedef struct packed {
    logic              accepted;
    logic [SLOT_W-1:0] slot;
    logic              full_res;
    logic [MASK_W-1:0] freed_mask;
  } result_t;

  // One table entry as it sits in the memory.
  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic             busy;
    logic [CNT_W-1:0] count;
    logic             running;
    logic             expired;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== sv/dfa_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
`default_nettype none
module dfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/dfa_core.sv =====
// Table sequencer: walks the entry memory once per item and updates it.
`default_nettype none
module dfa_core
  import dfa_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire item_t            item,
  input  wire logic [CNT_W-1:0] timeout,
  input  wire logic             out_free,
  output      logic             idle,
  output      logic             done,
  output      result_t          res
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int ENT_W = $bits(entry_t);

  state_t state, state_next;

  item_t             item_q;
  logic [IDX_W-1:0]  idx;
  logic              issued_all;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;
  logic              rd_vld;
  logic [ENTRIES-1:0] vld;
  logic              table_full;

  logic              seen;
  logic              ff_found;
  logic              sf_found;
  logic [IDX_W-1:0]  ff_idx;
  logic              accepted;
  logic [SLOT_W-1:0] slot;
  logic [MASK_W-1:0] freed;

  logic              issue;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  entry_t            wentry;
  logic [ENT_W-1:0]  ram_q;
  entry_t            rd_entry;
  entry_t            tick_entry;
  entry_t            new_entry;
  logic              store;

  dfa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .re    (issue),
    .raddr (idx),
    .rdata (ram_q)
  );

  // An entry never written reads as all zero.
  assign rd_entry = rd_vld ? entry_t'(ram_q) : '0;

  always_comb begin
    tick_entry = rd_entry;
    if (rd_entry.expired) begin
      tick_entry.expired = 1'b0;
      tick_entry.pattern = '0;
      tick_entry.busy    = 1'b0;
    end
    if (rd_entry.running) begin
      if (rd_entry.count <= CNT_W'(1)) begin
        tick_entry.count   = '0;
        tick_entry.running = 1'b0;
        tick_entry.expired = 1'b1;
      end else begin
        tick_entry.count = rd_entry.count - CNT_W'(1);
      end
    end
  end

  always_comb begin
    new_entry         = '0;
    new_entry.pattern = item_q.pattern;
    new_entry.busy    = 1'b1;
    new_entry.count   = timeout;
    new_entry.running = 1'b1;
  end

  assign store = !table_full && !seen && ff_found;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_SCAN;
      ST_SCAN: begin
        if (issued_all && !pend) begin
          state_next = (item_q.func == FUNC_ARRIVE) ? ST_WRITE : ST_DONE;
        end
      end
      ST_WRITE: state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    issue  = 1'b0;
    we     = 1'b0;
    waddr  = pend_idx;
    wentry = tick_entry;
    done   = 1'b0;
    idle   = 1'b0;
    case (state)
      ST_IDLE: idle = 1'b1;
      ST_SCAN: begin
        issue = !issued_all;
        we    = pend && (item_q.func == FUNC_TICK);
      end
      ST_WRITE: begin
        we     = store;
        waddr  = ff_idx;
        wentry = new_entry;
      end
      ST_DONE: done = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend       <= 1'b0;
      issued_all <= 1'b0;
      vld        <= '0;
      table_full <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= issue;
      if (start && idle) begin
        issued_all <= 1'b0;
      end else if (issue && idx == IDX_W'(ENTRIES - 1)) begin
        issued_all <= 1'b1;
      end
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (state == ST_SCAN && pend && item_q.func == FUNC_TICK && rd_entry.expired) begin
        table_full <= 1'b0;
      end
      if (state == ST_WRITE && !table_full && !seen) begin
        table_full <= ff_found ? !sf_found : 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && idle) begin
      item_q   <= item;
      idx      <= '0;
      seen     <= 1'b0;
      ff_found <= 1'b0;
      sf_found <= 1'b0;
      accepted <= 1'b0;
      slot     <= '0;
      freed    <= '0;
    end else begin
      if (issue) begin
        idx      <= idx + IDX_W'(1);
        pend_idx <= idx;
        rd_vld   <= vld[idx];
      end
      if (state == ST_SCAN && pend) begin
        if (item_q.func == FUNC_ARRIVE) begin
          if (rd_entry.pattern == item_q.pattern) begin
            seen <= 1'b1;
          end
          if (!rd_entry.busy) begin
            if (!ff_found) begin
              ff_found <= 1'b1;
              ff_idx   <= pend_idx;
            end else begin
              sf_found <= 1'b1;
            end
          end
        end else if (rd_entry.expired) begin
          for (int b = 0; b < MASK_W; b++) begin
            if (b < ENTRIES && pend_idx == IDX_W'(b)) begin
              freed[b] <= 1'b1;
            end
          end
        end
      end
      if (state == ST_WRITE) begin
        accepted <= store;
        slot     <= store ? SLOT_W'(ff_idx) : '0;
      end
    end
  end

  always_comb begin
    res            = '0;
    res.accepted   = accepted;
    res.slot       = slot;
    res.full_res   = table_full;
    res.freed_mask = freed;
  end

endmodule
`default_nettype wire

// ===== sv/duplicate_filter_with_aging.sv =====
// Top level of the duplicate filter with aging: ports, register, result stage.
//
//  Channel  Direction  Handshake            Beat
//  item     in         item_valid/stall     func, pattern
//  result   out        result_valid/stall   accepted, slot, full_res, freed_mask
//  cfg      in         cfg_valid/cfg_ready  timeout_ticks
//
// Each item walks the entry memory once, one read a cycle; a pattern beat then
// passes a write state before its result is loaded. The sequencer takes the
// next item in the cycle after that load.
// Reset is synchronous and active high; valid bits make unwritten entries read
// as zero. A waiting result holds in its register while result_stall is high;
// the next item is taken meanwhile and only its result write waits.
`default_nettype none
`include "duplicate_filter_with_aging_defines.svh"
module duplicate_filter_with_aging
  import dfa_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output      logic             item_stall,
  input  wire item_t            item,
  output      logic             result_valid,
  input  wire logic             result_stall,
  output      result_t          result,
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  logic [CNT_W-1:0] timeout_ticks;
  logic             core_idle;
  logic             core_done;
  result_t          core_res;
  logic             out_free;

  // The register may be written at any time; the user only does so between items.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

  // The sequencer takes a new item whenever it is idle.
  assign item_stall = !core_idle;

  // The result register may be loaded when empty or when its beat leaves now.
  assign out_free = !result_valid || !result_stall;

  dfa_core #(
    .ENTRIES (ENTRIES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (item_valid),
    .item     (item),
    .timeout  (timeout_ticks),
    .out_free (out_free),
    .idle     (core_idle),
    .done     (core_done),
    .res      (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (core_done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_done) begin
      result <= core_res;
    end
  end

  // The sequencer stays busy, stalling the item channel, after it takes an item.
  `DFA_ASSERT_NEXT(a_busy_after_take, item_valid && !item_stall, item_stall)

  // A stored pattern comes from an arrival, which never frees a slot.
  `DFA_ASSERT_NOW(a_store_frees_none, result_valid && result.accepted, result.freed_mask == '0)

endmodule
`default_nettype wire
